// ===== hw/rtl/exclusion_zone_point_filter_macros.svh =====
// Assertion helpers for the zone filter top level.
`ifndef EXCLUSION_ZONE_POINT_FILTER_MACROS_SVH
`define EXCLUSION_ZONE_POINT_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EZPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EZPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ezpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ezpf_pkg
// Types and constants of the exclusion zone point filter.
// ----------------------------------------------------------------------------
package ezpf_pkg;

    localparam int POS_W  = 24;
    localparam int SIZE_W = 23;
    localparam int TAG_W  = 8;
    localparam int DIFF_W = POS_W + 2;

    // 5.0 units in Q16.8, squared
    localparam logic [2*DIFF_W:0] SOFT_RECT_SQ = (2*DIFF_W+1)'(1638400);

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic [TAG_W-1:0]         tag;
        logic                     circle;
        logic                     soft_edge;
        logic                     incl;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  pz;
        logic [SIZE_W-1:0]        a;
        logic [SIZE_W-1:0]        b;
    } t_zone;

    typedef struct packed {
        logic shift;
        logic wr;
        logic clr;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/ezpf_cell.sv =====
// ----------------------------------------------------------------------------
// ezpf_cell
// One zone table entry; passes its entry to the previous cell while shifting.
// ----------------------------------------------------------------------------
module ezpf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ezpf_pkg::t_cell_ctl i_ctl,
    input  ezpf_pkg::t_zone    i_next,
    input  ezpf_pkg::t_zone    i_wr_zone,
    output ezpf_pkg::t_zone    o_zone
);

    ezpf_pkg::t_zone r_zone;
    ezpf_pkg::t_zone n_zone;

    always_comb begin
        n_zone = r_zone;
        if (i_ctl.shift) begin
            n_zone = i_next;
        end else if (i_ctl.wr) begin
            n_zone = i_wr_zone;
        end else if (i_ctl.clr) begin
            n_zone.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else begin
            r_zone <= n_zone;
        end
    end

    assign o_zone = r_zone;

endmodule

// ===== hw/rtl/ezpf_eval.sv =====
// ----------------------------------------------------------------------------
// ezpf_eval
// Three-stage zone test: distances, squares, scaled compare.
// ----------------------------------------------------------------------------
module ezpf_eval (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  ezpf_pkg::t_zone                      i_zone,
    input  logic signed [ezpf_pkg::POS_W-1:0]    i_x,
    input  logic signed [ezpf_pkg::POS_W-1:0]    i_z,
    output logic                                 o_valid,
    output logic                                 o_incl,
    output logic                                 o_hit
);

    localparam int DW  = ezpf_pkg::DIFF_W;
    localparam int SW  = ezpf_pkg::SIZE_W;
    localparam int QW  = 2 * DW + 1;
    localparam int CW  = QW + 7;

    // stage 1
    logic signed [DW-1:0] xe, ze, pxe, pze, ae, be;
    logic signed [DW-1:0] x_lo, x_hi, z_lo, z_hi;
    logic signed [DW-1:0] n_dx, n_dz;
    logic signed [DW-1:0] r_dx, r_dz;
    logic [SW-1:0]        r_a1;
    logic                 r_v1, r_incl1, r_circ1, r_soft1, r_rin1;

    assign xe  = DW'(i_x);
    assign ze  = DW'(i_z);
    assign pxe = DW'(i_zone.px);
    assign pze = DW'(i_zone.pz);
    assign ae  = DW'(i_zone.a);
    assign be  = DW'(i_zone.b);
    assign x_lo = pxe - xe;
    assign x_hi = xe - (pxe + ae);
    assign z_lo = pze - ze;
    assign z_hi = ze - (pze + be);

    always_comb begin
        if (i_zone.circle) begin
            n_dx = xe - pxe;
            n_dz = ze - pze;
        end else begin
            n_dx = (x_lo > 0) ? x_lo : ((x_hi > 0) ? x_hi : '0);
            n_dz = (z_lo > 0) ? z_lo : ((z_hi > 0) ? z_hi : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;
        r_dz    <= n_dz;
        r_a1    <= i_zone.a;
        r_incl1 <= i_zone.incl;
        r_circ1 <= i_zone.circle;
        r_soft1 <= i_zone.soft_edge;
        r_rin1  <= (x_lo <= 0) && (x_hi <= 0) && (z_lo <= 0) && (z_hi <= 0);
        r_v1    <= i_rst_n ? i_valid : 1'b0;
    end

    // stage 2
    logic signed [2*DW-1:0] sqx, sqz;
    logic [2*DW-1:0]        r_sqx, r_sqz;
    logic [2*SW-1:0]        r_r2;
    logic                   r_v2, r_incl2, r_circ2, r_soft2, r_rin2;

    assign sqx = r_dx * r_dx;
    assign sqz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_sqx   <= $unsigned(sqx);
        r_sqz   <= $unsigned(sqz);
        r_r2    <= r_a1 * r_a1;
        r_incl2 <= r_incl1;
        r_circ2 <= r_circ1;
        r_soft2 <= r_soft1;
        r_rin2  <= r_rin1;
        r_v2    <= i_rst_n ? r_v1 : 1'b0;
    end

    // stage 3
    logic [QW-1:0] d2;
    logic [CW-1:0] d2_100, r2_121, r2w;
    logic          n_hit;
    logic          r_v3, r_incl3, r_hit3;

    assign d2     = QW'(r_sqx) + QW'(r_sqz);
    assign r2w    = CW'(r_r2);
    assign d2_100 = (CW'(d2) << 6) + (CW'(d2) << 5) + (CW'(d2) << 2);
    assign r2_121 = (r2w << 7) - (r2w << 3) + r2w;

    always_comb begin
        if (r_circ2) begin
            n_hit = r_soft2 ? (d2_100 < r2_121) : (CW'(d2) <= r2w);
        end else begin
            n_hit = r_soft2 ? (d2 < ezpf_pkg::SOFT_RECT_SQ) : r_rin2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit3  <= n_hit;
        r_incl3 <= r_incl2;
        r_v3    <= i_rst_n ? r_v2 : 1'b0;
    end

    assign o_valid = r_v3;
    assign o_incl  = r_incl3;
    assign o_hit   = r_hit3;

endmodule

// ===== hw/rtl/exclusion_zone_point_filter.sv =====
// After an item is accepted, the zone ring rotates once past the head
// cell (one zone a cycle), then the three-stage zone test drains and the
// result is registered.
// A new transaction is taken only in the idle state, once the ring rotation,
// drain and result load of the last one are done.
// Reset (i_rst_n low, synchronous) empties the zone table and idles control.
// ----------------------------------------------------------------------------
// exclusion_zone_point_filter
// Zone table of circles and rectangles; queries test a point against all.
// ----------------------------------------------------------------------------
`include "exclusion_zone_point_filter_macros.svh"

module exclusion_zone_point_filter #(
    parameter int MAX_ZONES   = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: zone_id[7:0], is_circle[8], soft_edge[9], inclusion[10],
    //        pos_x[34:11], pos_z[58:35], size_a[81:59], size_b[104:82], zero pad
    input  logic [111:0] s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: allowed[0], status[1], zero pad
    output logic [7:0]   m_tdata
);

    localparam int PW    = (COORD_WIDTH < ezpf_pkg::POS_W) ? COORD_WIDTH : ezpf_pkg::POS_W;
    localparam int SZW   = PW - 1;
    localparam int IDX_W = $clog2(MAX_ZONES);
    localparam int CNT_W = $clog2((MAX_ZONES > 4) ? MAX_ZONES : 4);
    localparam int DRAIN_LAST = 3;

    ezpf_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    ezpf_pkg::t_cmd   r_cmd;
    ezpf_pkg::t_zone  r_in;
    logic             r_hit, r_free;
    logic [IDX_W-1:0] r_hit_idx, r_free_idx;
    logic             r_any_incl, r_in_incl, r_excl;
    logic             r_ovalid;
    logic [1:0]       r_odata;

    logic             s_acc, m_acc, run_last, drain_first, out_load;
    logic             issue, do_wr, do_clr;
    logic [IDX_W-1:0] slot;
    logic [MAX_ZONES-1:0] wr_vec;

    ezpf_pkg::t_zone  zones [MAX_ZONES];
    ezpf_pkg::t_zone  head_mod;
    ezpf_pkg::t_zone  in_zone;

    logic signed [PW-1:0] x_t, z_t;
    logic ev_valid, ev_incl, ev_hit;

    assign x_t = s_tdata[11 +: PW];
    assign z_t = s_tdata[35 +: PW];

    always_comb begin
        in_zone           = '0;
        in_zone.valid     = 1'b1;
        in_zone.tag       = s_tdata[7:0];
        in_zone.circle    = s_tdata[8];
        in_zone.soft_edge = s_tdata[9];
        in_zone.incl      = s_tdata[10];
        in_zone.px        = ezpf_pkg::POS_W'(x_t);
        in_zone.pz        = ezpf_pkg::POS_W'(z_t);
        in_zone.a         = ezpf_pkg::SIZE_W'(s_tdata[59 +: SZW]);
        in_zone.b         = ezpf_pkg::SIZE_W'(s_tdata[82 +: SZW]);
    end

    assign s_acc       = s_tvalid && s_tready;
    assign m_acc       = m_tvalid && m_tready;
    assign run_last    = (r_cnt == CNT_W'(MAX_ZONES - 1));
    assign drain_first = (r_state == ezpf_pkg::ST_DRAIN) && (r_cnt == '0);
    assign out_load    = (r_state == ezpf_pkg::ST_FINISH) && (!r_ovalid || m_tready);
    assign slot        = r_hit ? r_hit_idx : r_free_idx;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ezpf_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (s_acc) begin
                    n_state = ezpf_pkg::ST_RUN;
                end
            end
            ezpf_pkg::ST_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (run_last) begin
                    n_state = ezpf_pkg::ST_DRAIN;
                    n_cnt   = '0;
                end
            end
            ezpf_pkg::ST_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DRAIN_LAST)) begin
                    n_state = ezpf_pkg::ST_FINISH;
                end
            end
            ezpf_pkg::ST_FINISH: begin
                if (out_load) begin
                    n_state = ezpf_pkg::ST_IDLE;
                end
            end
            default: n_state = ezpf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        do_wr    = 1'b0;
        do_clr   = 1'b0;
        case (r_state)
            ezpf_pkg::ST_IDLE: s_tready = 1'b1;
            ezpf_pkg::ST_RUN:  issue = zones[0].valid && (r_cmd == ezpf_pkg::CMD_QUERY);
            ezpf_pkg::ST_DRAIN: begin
                do_wr  = drain_first && (r_cmd == ezpf_pkg::CMD_ADD) && (r_hit || r_free);
                do_clr = drain_first && (r_cmd == ezpf_pkg::CMD_CLEAR);
            end
            default: ;
        endcase
    end

    // drop the head entry on a matching remove as it wraps around
    always_comb begin
        head_mod = zones[0];
        if (r_cmd == ezpf_pkg::CMD_REMOVE && zones[0].tag == r_in.tag) begin
            head_mod.valid = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ZONES; gi++) begin : g_cell
            ezpf_pkg::t_cell_ctl ctl;
            assign wr_vec[gi] = do_wr && (slot == IDX_W'(gi));
            assign ctl.shift  = (r_state == ezpf_pkg::ST_RUN);
            assign ctl.wr     = wr_vec[gi];
            assign ctl.clr    = do_clr;
            if (gi == MAX_ZONES - 1) begin : g_tail
                ezpf_cell u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
                    .i_next(head_mod), .i_wr_zone(r_in), .o_zone(zones[gi])
                );
            end else begin : g_body
                ezpf_cell u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
                    .i_next(zones[gi+1]), .i_wr_zone(r_in), .o_zone(zones[gi])
                );
            end
        end
    endgenerate

    ezpf_eval u_eval (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(issue), .i_zone(zones[0]),
        .i_x(r_in.px), .i_z(r_in.pz),
        .o_valid(ev_valid), .o_incl(ev_incl), .o_hit(ev_hit)
    );

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd <= ezpf_pkg::t_cmd'(s_tuser);
            r_in  <= in_zone;
        end
        if (!i_rst_n) begin
            r_state    <= ezpf_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_any_incl <= 1'b0;
            r_in_incl  <= 1'b0;
            r_excl     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (s_acc) begin
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_any_incl <= 1'b0;
                r_in_incl  <= 1'b0;
                r_excl     <= 1'b0;
            end else begin
                if (r_state == ezpf_pkg::ST_RUN) begin
                    // first entry with the tag, else first free entry
                    if (!r_hit && zones[0].valid && zones[0].tag == r_in.tag) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cnt[IDX_W-1:0];
                    end
                    if (!r_free && !zones[0].valid) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_cnt[IDX_W-1:0];
                    end
                end
                if (ev_valid) begin
                    if (ev_incl) begin
                        r_any_incl <= 1'b1;
                        r_in_incl  <= r_in_incl | ev_hit;
                    end else if (ev_hit) begin
                        r_excl <= 1'b1;
                    end
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_acc) begin
                r_ovalid <= 1'b0;
            end
        end
        if (out_load) begin
            r_odata <= {(r_cmd == ezpf_pkg::CMD_ADD) && !r_hit && !r_free,
                        (r_cmd == ezpf_pkg::CMD_QUERY) && !r_excl
                        && (!r_any_incl || r_in_incl)};
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {6'b0, r_odata};

    `EZPF_ASSERT_NXT(a_acc_run, s_acc, r_state == ezpf_pkg::ST_RUN, "accept did not start pass")
    `EZPF_ASSERT_NXT(a_run_end, (r_state == ezpf_pkg::ST_RUN) && run_last, r_state == ezpf_pkg::ST_DRAIN, "pass overran the ring")
    `EZPF_ASSERT_IMP(a_wr_one, 1'b1, $onehot0(wr_vec), "more than one cell written")
    `EZPF_ASSERT_IMP(a_out_excl, m_tvalid, !(m_tdata[0] && m_tdata[1]), "allowed and full both set")

endmodule

// ===== tb/zone_filter_checker.sv =====
// ----------------------------------------------------------------------------
// zone_filter_checker
// Watches both streams of the zone filter, keeps its own zone table, predicts
// the allowed and status bits of every command and compares them in order.
// ----------------------------------------------------------------------------
module zone_filter_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [7:0]   i_m_tdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_queries,
    output int           o_allowed_cnt,
    output int           o_full_cnt
);
    localparam int NZ = 16;

    typedef struct packed {
        logic allowed;
        logic status;
    } t_verdict;

    ezpf_pkg::t_zone table_q [NZ];
    t_verdict        verdicts [$];

    function automatic longint sqr(longint v);
        return v * v;
    endfunction

    function automatic bit zone_hit(ezpf_pkg::t_zone zn, longint x, longint z);
        longint px, pz, a, b, dx, dz, d2;
        px = zn.px; pz = zn.pz; a = zn.a; b = zn.b;
        if (zn.circle) begin
            d2 = sqr(x - px) + sqr(z - pz);
            if (zn.soft_edge) return 100 * d2 < 121 * sqr(a);
            return d2 <= sqr(a);
        end
        if (zn.soft_edge) begin
            dx = 0; dz = 0;
            if (px - x > dx) dx = px - x;
            if (x - (px + a) > dx) dx = x - (px + a);
            if (pz - z > dz) dz = pz - z;
            if (z - (pz + b) > dz) dz = z - (pz + b);
            return sqr(dx) + sqr(dz) < 1638400;
        end
        return x >= px && x <= px + a && z >= pz && z <= pz + b;
    endfunction

    function automatic t_verdict apply_command(ezpf_pkg::t_cmd cmd, logic [111:0] d);
        t_verdict        v;
        ezpf_pkg::t_zone zn;
        longint          x, z;
        bit              any_incl, in_incl, blocked;
        int              slot;
        v = '0;
        zn.valid     = 1'b1;
        zn.tag       = d[7:0];
        zn.circle    = d[8];
        zn.soft_edge = d[9];
        zn.incl      = d[10];
        zn.px        = d[34:11];
        zn.pz        = d[58:35];
        zn.a         = d[81:59];
        zn.b         = d[104:82];
        x = zn.px;
        z = zn.pz;
        case (cmd)
            ezpf_pkg::CMD_QUERY: begin
                any_incl = 0; in_incl = 0; blocked = 0;
                foreach (table_q[k]) begin
                    if (table_q[k].valid) begin
                        if (table_q[k].incl) begin
                            any_incl = 1;
                            if (zone_hit(table_q[k], x, z)) in_incl = 1;
                        end else if (zone_hit(table_q[k], x, z)) begin
                            blocked = 1;
                        end
                    end
                end
                v.allowed = !blocked && (!any_incl || in_incl);
            end
            ezpf_pkg::CMD_ADD: begin
                slot = -1;
                for (int k = 0; k < NZ && slot < 0; k++)
                    if (table_q[k].valid && table_q[k].tag == zn.tag) slot = k;
                for (int k = 0; k < NZ && slot < 0; k++)
                    if (!table_q[k].valid) slot = k;
                if (slot < 0) v.status = 1'b1;
                else table_q[slot] = zn;
            end
            ezpf_pkg::CMD_REMOVE: begin
                foreach (table_q[k])
                    if (table_q[k].valid && table_q[k].tag == zn.tag)
                        table_q[k].valid = 1'b0;
            end
            default: begin
                foreach (table_q[k]) table_q[k].valid = 1'b0;
            end
        endcase
        return v;
    endfunction

    assign o_pending = verdicts.size();

    always @(posedge i_clk) begin
        t_verdict exp_v;
        int       errs_now;
        errs_now = 0;
        if (!i_rst_n) begin
            foreach (table_q[k]) table_q[k] = '0;
            verdicts.delete();
            o_errors <= 0;
            o_queries <= 0;
            o_allowed_cnt <= 0;
            o_full_cnt <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (verdicts.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_m_tdata);
                    errs_now = errs_now + 1;
                end else begin
                    exp_v = verdicts.pop_front();
                    if (i_m_tdata[0] !== exp_v.allowed) begin
                        $display("%0t: allowed expected %b actual %b",
                                 $time, exp_v.allowed, i_m_tdata[0]);
                        errs_now = errs_now + 1;
                    end
                    if (i_m_tdata[1] !== exp_v.status) begin
                        $display("%0t: status expected %b actual %b",
                                 $time, exp_v.status, i_m_tdata[1]);
                        errs_now = errs_now + 1;
                    end
                end
            end
            o_errors <= o_errors + errs_now;
            if (i_s_tvalid && i_s_tready) begin
                exp_v = apply_command(ezpf_pkg::t_cmd'(i_s_tuser), i_s_tdata);
                verdicts.insert(verdicts.size(), exp_v);
                if (ezpf_pkg::t_cmd'(i_s_tuser) == ezpf_pkg::CMD_QUERY) begin
                    o_queries <= o_queries + 1;
                    o_allowed_cnt <= o_allowed_cnt + int'(exp_v.allowed);
                end
                o_full_cnt <= o_full_cnt + int'(exp_v.status);
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives zone table commands and query points into the zone filter with
// random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    int           errors, pending, queries, allowed_cnt, full_cnt;
    bit           stim_done = 0;

    always #5 i_clk = ~i_clk;

    exclusion_zone_point_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    zone_filter_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .o_errors(errors), .o_pending(pending),
        .o_queries(queries), .o_allowed_cnt(allowed_cnt), .o_full_cnt(full_cnt)
    );

    function automatic logic [111:0] pack_item(logic [7:0] tag, logic circ, logic soft_edge,
                                              logic incl, logic [23:0] x, logic [23:0] z,
                                              logic [22:0] a, logic [22:0] b);
        return {7'd0, b, a, z, x, incl, soft_edge, circ, tag};
    endfunction

    // Send one transaction, with a random gap first; valid stays high if gap is 0.
    task automatic send(ezpf_pkg::t_cmd cmd, logic [111:0] d);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Small coordinates keep points near zones so both outcomes are common.
    function automatic logic [23:0] near_coord();
        int v;
        v = $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 16384)) - 8192;
        return v[23:0];
    endfunction

    function automatic logic [22:0] near_size();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = $urandom;
            default: v = $urandom_range(1, 4096);
        endcase
        return v[22:0];
    endfunction

    task automatic random_item();
        int             r;
        ezpf_pkg::t_cmd cmd;
        logic [111:0]   d;
        r = $urandom_range(0, 99);
        if (r < 55) cmd = ezpf_pkg::CMD_QUERY;
        else if (r < 85) cmd = ezpf_pkg::CMD_ADD;
        else if (r < 97) cmd = ezpf_pkg::CMD_REMOVE;
        else cmd = ezpf_pkg::CMD_CLEAR;
        d = pack_item($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 23)),
                      1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                      near_coord(), near_coord(), near_size(), near_size());
        if ($urandom_range(0, 1)) d[111:105] = 7'($urandom);
        send(cmd, d);
    endtask

    // Receiver: random stalls per result, and stretches of none.
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (m_tready && m_tvalid) begin
                stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_tready <= 1'b1;
            end else if (i_rst_n) begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Empty table, extreme points.
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'h7FFFFF, 24'h800000, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'hFF, 1'b1, 1'b1, 1'b1,
                                            24'h800000, 24'h7FFFFF, '1, '1));
        // Zero-radius hard and soft circles at the origin.
        send(ezpf_pkg::CMD_ADD, pack_item(8'd1, 1'b1, 1'b0, 1'b0, 24'd0, 24'd0, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_QUERY, '0);
        send(ezpf_pkg::CMD_ADD, pack_item(8'd1, 1'b1, 1'b1, 1'b0, 24'd0, 24'd0, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_QUERY, '0);
        // Soft circle edge: radius 1000, points at 1099 and 1100.
        send(ezpf_pkg::CMD_ADD, pack_item(8'd2, 1'b1, 1'b1, 1'b0,
                                          24'd0, 24'd0, 23'd1000, 23'd0));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'd1099, 24'd0, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'd1100, 24'd0, 23'd0, 23'd0));
        // Soft rectangle margin, degenerate rectangle, inclusion zone.
        send(ezpf_pkg::CMD_ADD, pack_item(8'd3, 1'b0, 1'b1, 1'b0,
                                          24'd5000, 24'd5000, 23'd0, 23'd100));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'd3721, 24'd5000, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'd3720, 24'd5000, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_ADD, pack_item(8'd4, 1'b0, 1'b0, 1'b1,
                                          24'h800000, 24'h800000, '1, '1));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'h800000, 24'hFFFFFF, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'h7FFFFF, 24'h7FFFFF, 23'd0, 23'd0));
        // Remove absent tag, fill the table, overflow, replace, clear.
        send(ezpf_pkg::CMD_REMOVE, pack_item(8'hEE, 1'b0, 1'b0, 1'b0,
                                             24'd0, 24'd0, 23'd0, 23'd0));
        for (int k = 0; k < 13; k++)
            send(ezpf_pkg::CMD_ADD, pack_item(8'(16 + k), 1'b0, 1'b0, 1'b0,
                                              24'd100000, 24'd0, 23'd1, 23'd1));
        send(ezpf_pkg::CMD_ADD, pack_item(8'hFE, 1'b1, 1'b0, 1'b0,
                                          24'd0, 24'd0, 23'd5, 23'd0));
        send(ezpf_pkg::CMD_ADD, pack_item(8'd2, 1'b1, 1'b0, 1'b0,
                                          24'd0, 24'd0, 23'd5, 23'd0));
        send(ezpf_pkg::CMD_QUERY, pack_item(8'd0, 1'b0, 1'b0, 1'b0,
                                            24'd1099, 24'd0, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_REMOVE, pack_item(8'd4, 1'b0, 1'b0, 1'b0,
                                             24'd0, 24'd0, 23'd0, 23'd0));
        send(ezpf_pkg::CMD_CLEAR, '0);
        for (int n = 0; n < 1510; n++) random_item();
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d queries (%0d allowed) and %0d dropped adds",
                 queries, allowed_cnt, full_cnt);
        if (errors == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("testbench failed");
        $finish;
    end
endmodule
